FILE: sv/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants of the soft timer bank: field widths, command,
// status and internal operation codes, and the queued operation record.
// ----------------------------------------------------------------------------
package stb_pkg;

   localparam int NUM_TIMERS  = 8;
   localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int USED_W      = $clog2(NUM_TIMERS + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CMD_W       = 3;
   localparam int ID_W        = 3;
   localparam int PERIOD_W    = 16;
   localparam int OPT_W       = 2;
   localparam int STATUS_W    = 3;

   localparam int OPT_AUTORESET_BIT = 0;
   localparam int OPT_AUTOSTOP_BIT  = 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER = 3'd0,
      CMD_RESET    = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_RUN      = 3'd3,
      CMD_CHECK    = 3'd4,
      CMD_TICK     = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_PERIOD   = 3'd2,
      ST_CONFLICT = 3'd3,
      ST_UNKNOWN  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_REGISTER,
      OP_RELOAD,
      OP_STOP,
      OP_CHECK,
      OP_TICK,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [ID_W-1:0]       timer_id;
      logic [PERIOD_W-1:0]   period;
      logic [OPT_W-1:0]      option_bits;
      logic                  period_bad;
      logic                  opt_conflict;
   } op_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: sv/stb_req_if.sv
// ----------------------------------------------------------------------------
// stb_req_if
// Command channel of the soft timer bank: valid/ready plus command fields.
// ----------------------------------------------------------------------------
interface stb_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [2:0]  timer_id;
   logic [15:0] period;
   logic [1:0]  option_bits;

   modport source (output valid, output cmd, output timer_id, output period,
                   output option_bits, input ready);
   modport sink   (input valid, input cmd, input timer_id, input period,
                   input option_bits, output ready);
endinterface

FILE: sv/stb_rsp_if.sv
// ----------------------------------------------------------------------------
// stb_rsp_if
// Response channel of the soft timer bank: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface stb_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic       expired;
   logic [2:0] new_id;

   modport source (output valid, output status, output expired, output new_id,
                   input ready);
   modport sink   (input valid, input status, input expired, input new_id,
                   output ready);
endinterface

FILE: sv/stb_front.sv
// ----------------------------------------------------------------------------
// stb_front
// Accepts command transactions, holds the period limit register and turns
// each command into a queued operation with its static checks done.
// ----------------------------------------------------------------------------
module stb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [15:0]              csr_wdata,
   stb_req_if.sink                  req_ch,
   input  stb_pkg::queue_status_type q_status,
   output logic                     push,
   output stb_pkg::op_entry_type    entry
);

   logic [stb_pkg::PERIOD_W-1:0] period_limit_ff;
   logic [stb_pkg::PERIOD_W-1:0] period_limit_in;
   stb_pkg::op_type              op;

   assign period_limit_in = csr_we ? csr_wdata : period_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_limit_ff <= '1;
      end else begin
         period_limit_ff <= period_limit_in;
      end
   end

   assign req_ch.ready = !q_status.full;
   assign push         = req_ch.valid && !q_status.full;

   always_comb begin
      case (stb_pkg::cmd_type'(req_ch.cmd))
         stb_pkg::CMD_REGISTER: op = stb_pkg::OP_REGISTER;
         stb_pkg::CMD_RESET:    op = stb_pkg::OP_RELOAD;
         stb_pkg::CMD_RUN:      op = stb_pkg::OP_RELOAD;
         stb_pkg::CMD_STOP:     op = stb_pkg::OP_STOP;
         stb_pkg::CMD_CHECK:    op = stb_pkg::OP_CHECK;
         stb_pkg::CMD_TICK:     op = stb_pkg::OP_TICK;
         default:               op = stb_pkg::OP_NOP;
      endcase
   end

   always_comb begin
      entry.op           = op;
      entry.timer_id     = req_ch.timer_id;
      entry.period       = req_ch.period;
      entry.option_bits  = req_ch.option_bits;
      entry.period_bad   = req_ch.period > period_limit_ff;
      entry.opt_conflict = req_ch.option_bits[stb_pkg::OPT_AUTORESET_BIT] &&
                           req_ch.option_bits[stb_pkg::OPT_AUTOSTOP_BIT];
   end

endmodule

FILE: sv/stb_queue.sv
// ----------------------------------------------------------------------------
// stb_queue
// Short FIFO of classified operations between the front and the back end.
// ----------------------------------------------------------------------------
module stb_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  stb_pkg::op_entry_type     entry_in,
   input  logic                      pop,
   output stb_pkg::op_entry_type     entry_out,
   output stb_pkg::queue_status_type q_status
);

   stb_pkg::op_entry_type       slot_ff [stb_pkg::QUEUE_DEPTH];
   logic [stb_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [stb_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [stb_pkg::QCNT_W-1:0]  count_ff,  count_in;

   localparam logic [stb_pkg::QPTR_W-1:0] LAST_PTR =
      stb_pkg::QPTR_W'(stb_pkg::QUEUE_DEPTH - 1);

   assign q_status.full  = count_ff == stb_pkg::QCNT_W'(stb_pkg::QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign entry_out      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + stb_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + stb_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + stb_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - stb_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= stb_pkg::QCNT_W'(stb_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

FILE: sv/stb_back.sv
// ----------------------------------------------------------------------------
// stb_back
// Executes queued operations against the timer table and drives the
// response register. A tick walks the table one entry per cycle; its last step waits for a free response register.
// ----------------------------------------------------------------------------
module stb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  stb_pkg::queue_status_type q_status,
   input  stb_pkg::op_entry_type     entry,
   output logic                      pop,
   stb_rsp_if.source                 rsp_ch
);

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   localparam logic [stb_pkg::IDX_W-1:0] LAST_IDX =
      stb_pkg::IDX_W'(stb_pkg::NUM_TIMERS - 1);

   // timer table
   logic [stb_pkg::PERIOD_W-1:0] period_ff [stb_pkg::NUM_TIMERS];
   logic [stb_pkg::PERIOD_W-1:0] count_ff  [stb_pkg::NUM_TIMERS];
   logic [stb_pkg::OPT_W-1:0]    mode_ff   [stb_pkg::NUM_TIMERS];
   logic                         run_ff    [stb_pkg::NUM_TIMERS];

   state_type                    state_ff, state_in;
   logic [stb_pkg::IDX_W-1:0]    walk_idx_ff, walk_idx_in;
   logic [stb_pkg::USED_W-1:0]   used_count_ff, used_count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   stb_pkg::status_type          status_ff, status_in;
   logic                         expired_ff, expired_in;
   logic [stb_pkg::ID_W-1:0]     new_id_ff, new_id_in;

   logic                         out_free;
   logic                         known;
   logic                         full;
   logic                         walk_active;
   logic                         step_en;
   logic [stb_pkg::IDX_W-1:0]    id_idx, uc_idx, rd_idx;
   logic [stb_pkg::PERIOD_W-1:0] rd_period, rd_count;
   logic [stb_pkg::OPT_W-1:0]    rd_mode;
   logic                         rd_run;

   // table write ports
   logic                         tab_we;
   logic                         cnt_we;
   logic [stb_pkg::IDX_W-1:0]    cnt_wa;
   logic [stb_pkg::PERIOD_W-1:0] cnt_wd;
   logic                         run_we;
   logic                         run_wd;

   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign known       = int'(entry.timer_id) < int'(used_count_ff);
   assign full        = used_count_ff >= stb_pkg::USED_W'(stb_pkg::NUM_TIMERS);
   assign walk_active = int'(walk_idx_ff) < int'(used_count_ff);
   assign step_en     = (walk_idx_ff != LAST_IDX) || out_free;

   assign id_idx    = stb_pkg::IDX_W'(entry.timer_id);
   assign uc_idx    = stb_pkg::IDX_W'(used_count_ff);
   assign rd_idx    = (state_ff == S_WALK) ? walk_idx_ff : id_idx;
   assign rd_period = period_ff[rd_idx];
   assign rd_count  = count_ff[rd_idx];
   assign rd_mode   = mode_ff[rd_idx];
   assign rd_run    = run_ff[rd_idx];

   // a tick needs no response slot until its last step
   assign pop = (state_ff == S_IDLE) && !q_status.empty &&
                (out_free || entry.op == stb_pkg::OP_TICK);

   always_comb begin
      state_in      = state_ff;
      walk_idx_in   = walk_idx_ff;
      used_count_in = used_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      status_in     = status_ff;
      expired_in    = expired_ff;
      new_id_in     = new_id_ff;
      tab_we        = 1'b0;
      cnt_we        = 1'b0;
      cnt_wa        = rd_idx;
      cnt_wd        = rd_period;
      run_we        = 1'b0;
      run_wd        = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (pop && entry.op == stb_pkg::OP_TICK) begin
               state_in    = S_WALK;
               walk_idx_in = '0;
            end else if (pop) begin
               rsp_valid_in = 1'b1;
               status_in    = stb_pkg::ST_OK;
               expired_in   = 1'b0;
               new_id_in    = '0;
               case (entry.op)
                  stb_pkg::OP_REGISTER: begin
                     if (full) begin
                        status_in = stb_pkg::ST_FULL;
                     end else if (entry.period_bad) begin
                        status_in = stb_pkg::ST_PERIOD;
                     end else if (entry.opt_conflict) begin
                        status_in = stb_pkg::ST_CONFLICT;
                     end else begin
                        tab_we        = 1'b1;
                        cnt_we        = 1'b1;
                        cnt_wa        = uc_idx;
                        cnt_wd        = entry.period;
                        run_we        = 1'b1;
                        new_id_in     = stb_pkg::ID_W'(used_count_ff);
                        used_count_in = used_count_ff + stb_pkg::USED_W'(1);
                     end
                  end
                  stb_pkg::OP_RELOAD: begin
                     if (!known) begin
                        status_in = stb_pkg::ST_UNKNOWN;
                     end else begin
                        cnt_we = 1'b1;
                        run_we = 1'b1;
                     end
                  end
                  stb_pkg::OP_STOP: begin
                     if (!known) begin
                        status_in = stb_pkg::ST_UNKNOWN;
                     end else begin
                        cnt_we = 1'b1;
                        cnt_wd = '0;
                        run_we = 1'b1;
                        run_wd = 1'b0;
                     end
                  end
                  stb_pkg::OP_CHECK: begin
                     if (!known) begin
                        status_in = stb_pkg::ST_UNKNOWN;
                     end else if (rd_count == '0) begin
                        if (rd_mode[stb_pkg::OPT_AUTORESET_BIT]) begin
                           if (rd_run) begin
                              cnt_we     = 1'b1;
                              run_we     = 1'b1;
                              expired_in = 1'b1;
                           end
                        end else if (rd_mode[stb_pkg::OPT_AUTOSTOP_BIT] && rd_run) begin
                           run_we     = 1'b1;
                           run_wd     = 1'b0;
                           expired_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            if (step_en) begin
               if (walk_active && rd_run && rd_count != '0) begin
                  cnt_we = 1'b1;
                  cnt_wd = rd_count - stb_pkg::PERIOD_W'(1);
               end
               if (walk_idx_ff == LAST_IDX) begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
                  status_in    = stb_pkg::ST_OK;
                  expired_in   = 1'b0;
                  new_id_in    = '0;
               end else begin
                  walk_idx_in = walk_idx_ff + stb_pkg::IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         walk_idx_ff   <= '0;
         used_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_idx_ff   <= walk_idx_in;
         used_count_ff <= used_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      status_ff  <= status_in;
      expired_ff <= expired_in;
      new_id_ff  <= new_id_in;
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         period_ff[uc_idx] <= entry.period;
         mode_ff[uc_idx]   <= entry.option_bits;
      end
      if (cnt_we) begin
         count_ff[cnt_wa] <= cnt_wd;
      end
      if (run_we) begin
         run_ff[cnt_wa] <= run_wd;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = status_ff;
   assign rsp_ch.expired = expired_ff;
   assign rsp_ch.new_id  = new_id_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= stb_pkg::USED_W'(stb_pkg::NUM_TIMERS))
      else $error("used count beyond table size");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (used_count_ff != $past(used_count_ff)) |->
      (used_count_ff == $past(used_count_ff) + stb_pkg::USED_W'(1)))
      else $error("used count moved by other than one");

   a_expired_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && expired_ff) |-> (status_ff == stb_pkg::ST_OK))
      else $error("expiry reported with error status");

   a_walk_no_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> !pop)
      else $error("queue popped during table walk");

endmodule

FILE: sv/soft_timer_bank.sv
// ----------------------------------------------------------------------------
// soft_timer_bank
// Bank of countdown timers handed out in order, driven by command
// transactions; one response transaction per command.
// ----------------------------------------------------------------------------
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    cmd, timer_id, period, option_bits
//   rsp_ch    out        valid/ready    status, expired, new_id
//   csr_*     in         write enable   period limit (16 bit)
//
// The front end takes one transaction per cycle, while the queue has room,
// into a two-entry queue. Register, reset, stop, run and check are done as
// their entry leaves the queue; a tick leaves the queue and then walks the
// table one entry at a time, from the first to the last.
// Responses sit in an output register; a stalled rsp_ch holds the back end
// and, once the queue fills, req_ch.ready drops.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module soft_timer_bank (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   stb_req_if.sink     req_ch,
   stb_rsp_if.source   rsp_ch
);

   stb_pkg::queue_status_type q_status;
   stb_pkg::op_entry_type     push_entry;
   stb_pkg::op_entry_type     pop_entry;
   logic                      push;
   logic                      pop;

   stb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .q_status  (q_status),
      .push      (push),
      .entry     (push_entry)
   );

   stb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry_in  (push_entry),
      .pop       (pop),
      .entry_out (pop_entry),
      .q_status  (q_status)
   );

   stb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .entry    (pop_entry),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
